@@ hw/rtl/hkds_pkg.sv @@
// Package for the keyboard descriptor scanner: descriptor type codes,
// scan phase and status types, register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hkds_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATCH_CLASS    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATCH_SUBCLASS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATCH_PROTOCOL = 2'd2;

   localparam logic [7:0] RESET_MATCH_CLASS    = 8'h03;
   localparam logic [7:0] RESET_MATCH_SUBCLASS = 8'h01;
   localparam logic [7:0] RESET_MATCH_PROTOCOL = 8'h01;

   localparam logic [7:0] TYPE_CONFIGURATION = 8'h02;
   localparam logic [7:0] TYPE_INTERFACE     = 8'h04;
   localparam logic [7:0] TYPE_ENDPOINT      = 8'h05;
   localparam logic [7:0] XFER_MASK          = 8'h03;
   localparam logic [7:0] XFER_INTERRUPT     = 8'h03;
   localparam logic [7:0] DIR_IN             = 8'h80;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SEARCH,
      PH_IN_IFACE,
      PH_FOUND,
      PH_BAD,
      PH_STOPPED
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND,
      ST_BAD_HEADER,
      ST_NOT_FOUND
   } status_type;

endpackage

`default_nettype wire

@@ hw/rtl/hkds_if.sv @@
// Channel interfaces of the keyboard descriptor scanner: byte request,
// scan result and register write. Depend on hkds_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hkds_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hkds_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] scan_status;
   logic [7:0] interface_number;
   logic [7:0] endpoint_address;
   logic [7:0] poll_interval;

   modport source (output valid, output scan_status, output interface_number,
                   output endpoint_address, output poll_interval, input ready);
   modport sink   (input valid, input scan_status, input interface_number,
                   input endpoint_address, input poll_interval, output ready);
endinterface

interface hkds_csr_if import hkds_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] reg_index;
   logic [7:0]                 wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hid_keyboard_descriptor_scanner.sv @@
// Top level of the keyboard descriptor scanner.
// Depends on hkds_pkg and the channel interfaces in hkds_if.sv.
//
// Scans a USB configuration descriptor, one byte per request, for a boot
// keyboard: an interface whose class, subclass and protocol equal the three
// match registers (reset 3/1/1), followed inside that interface by an
// interrupt IN endpoint. The request carrying last_byte yields exactly one
// result in the next cycle: found (with interface number, endpoint address and
// polling interval), bad configuration header, or not found; the three value
// fields read zero unless found. After that the scanner re-arms for the next
// stream. Throughput is one byte per cycle: each byte updates a small set of
// scan registers (offset, length, type, phase, captured fields), and the next
// byte reads them directly. The result register frees itself when taken, so
// requests keep flowing while a result waits, and stall only when a held
// result blocks a new one. Register writes are taken every cycle; indexes
// beyond the three registers are dropped.
`timescale 1ns / 1ps
`default_nettype none

module hid_keyboard_descriptor_scanner import hkds_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   hkds_req_if.sink   req_chan,
   hkds_rsp_if.source rsp_chan,
   hkds_csr_if.sink   csr_chan
);

   // match registers
   logic [7:0] match_class_ff, match_subclass_ff, match_protocol_ff;

   // scan state
   phase_type  phase_ff, phase_in;
   logic [7:0] offset_ff, offset_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] field_ff [3];
   logic [7:0] field_in [3];
   logic [7:0] found_if_ff, found_if_in;
   logic [7:0] found_ep_ff, found_ep_in;
   logic [7:0] found_iv_ff, found_iv_in;

   // result register
   logic       rsp_valid_ff;
   status_type rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_if_ff, rsp_if_in;
   logic [7:0] rsp_ep_ff, rsp_ep_in;
   logic [7:0] rsp_iv_ff, rsp_iv_in;

   logic       req_take;
   logic       advance;
   logic [7:0] len_use;
   logic [7:0] b;

   // accept a byte unless a held result would be overwritten
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready || !req_chan.last_byte;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_class_ff    <= RESET_MATCH_CLASS;
         match_subclass_ff <= RESET_MATCH_SUBCLASS;
         match_protocol_ff <= RESET_MATCH_PROTOCOL;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            CSR_MATCH_CLASS:    match_class_ff    <= csr_chan.wr_data;
            CSR_MATCH_SUBCLASS: match_subclass_ff <= csr_chan.wr_data;
            CSR_MATCH_PROTOCOL: match_protocol_ff <= csr_chan.wr_data;
            default: ;
         endcase
      end
   end

   // next scan state for the byte on the request channel
   always_comb begin
      phase_in    = phase_ff;
      offset_in   = offset_ff;
      length_in   = length_ff;
      type_in     = type_ff;
      field_in    = field_ff;
      found_if_in = found_if_ff;
      found_ep_in = found_ep_ff;
      found_iv_in = found_iv_ff;
      advance     = 1'b0;
      len_use     = length_ff;

      unique case (phase_ff)
         PH_HEADER: begin
            if (offset_ff == 8'd0) begin
               length_in = b;
               offset_in = 8'd1;
            end else if (b != TYPE_CONFIGURATION) begin
               phase_in = PH_BAD;
            end else begin
               phase_in = PH_SEARCH;
               type_in  = b;
               priority if (length_ff == 8'd0) begin
                  phase_in = PH_STOPPED;
               end else if (length_ff == 8'd1) begin
                  // header type byte doubles as the next length byte
                  length_in = TYPE_CONFIGURATION;
                  type_in   = 8'd0;
                  offset_in = 8'd1;
               end else if (length_ff == 8'd2) begin
                  offset_in = 8'd0;
               end else begin
                  offset_in = 8'd2;
               end
            end
         end
         PH_SEARCH, PH_IN_IFACE: begin
            advance = 1'b1;
            priority if (offset_ff == 8'd0) begin
               length_in = b;
               len_use   = b;
               type_in   = 8'd0;
               if (b == 8'd0) begin
                  // zero-length descriptor: stop the scan
                  phase_in = PH_STOPPED;
                  advance  = 1'b0;
               end
            end else if (offset_ff == 8'd1) begin
               type_in = b;
               if (b == TYPE_INTERFACE) begin
                  phase_in = PH_SEARCH;
               end
            end else if (type_ff == TYPE_INTERFACE && phase_ff == PH_SEARCH) begin
               priority if (offset_ff == 8'd2) begin
                  field_in[0] = b;
               end else if (offset_ff == 8'd5) begin
                  field_in[1] = b;
               end else if (offset_ff == 8'd6) begin
                  field_in[2] = b;
               end else if (offset_ff == 8'd7) begin
                  if (field_ff[1] == match_class_ff && field_ff[2] == match_subclass_ff &&
                      b == match_protocol_ff) begin
                     found_if_in = field_ff[0];
                     phase_in    = PH_IN_IFACE;
                  end
               end else begin
               end
            end else if (type_ff == TYPE_ENDPOINT && phase_ff == PH_IN_IFACE) begin
               priority if (offset_ff == 8'd2) begin
                  field_in[0] = b;
               end else if (offset_ff == 8'd3) begin
                  field_in[1] = b;
               end else if (offset_ff == 8'd6) begin
                  if ((field_ff[1] & XFER_MASK) == XFER_INTERRUPT &&
                      (field_ff[0] & DIR_IN) != 8'd0) begin
                     found_ep_in = field_ff[0];
                     found_iv_in = b;
                     phase_in    = PH_FOUND;
                     advance     = 1'b0;
                  end
               end else begin
               end
            end else begin
            end

            if (advance) begin
               if ({1'b0, offset_ff} + 9'd1 >= {1'b0, len_use}) begin
                  offset_in = 8'd0;
               end else begin
                  offset_in = offset_ff + 8'd1;
               end
            end
         end
         default: ;  // found, bad or stopped: ignore bytes until the mark
      endcase
   end

   // result for a marked byte, taken from the updated phase
   always_comb begin
      rsp_if_in = 8'd0;
      rsp_ep_in = 8'd0;
      rsp_iv_in = 8'd0;
      unique case (phase_in)
         PH_FOUND: begin
            rsp_status_in = ST_FOUND;
            rsp_if_in     = found_if_in;
            rsp_ep_in     = found_ep_in;
            rsp_iv_in     = found_iv_in;
         end
         PH_HEADER, PH_BAD: rsp_status_in = ST_BAD_HEADER;
         default:           rsp_status_in = ST_NOT_FOUND;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || (req_take && req_chan.last_byte)) begin
         // re-arm for a new stream
         phase_ff    <= PH_HEADER;
         offset_ff   <= 8'd0;
         length_ff   <= 8'd0;
         type_ff     <= 8'd0;
         field_ff    <= '{default: 8'd0};
         found_if_ff <= 8'd0;
         found_ep_ff <= 8'd0;
         found_iv_ff <= 8'd0;
      end else if (req_take) begin
         phase_ff    <= phase_in;
         offset_ff   <= offset_in;
         length_ff   <= length_in;
         type_ff     <= type_in;
         field_ff    <= field_in;
         found_if_ff <= found_if_in;
         found_ep_ff <= found_ep_in;
         found_iv_ff <= found_iv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take && req_chan.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_chan.last_byte) begin
         rsp_status_ff <= rsp_status_in;
         rsp_if_ff     <= rsp_if_in;
         rsp_ep_ff     <= rsp_ep_in;
         rsp_iv_ff     <= rsp_iv_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.scan_status      = rsp_status_ff;
   assign rsp_chan.interface_number = rsp_if_ff;
   assign rsp_chan.endpoint_address = rsp_ep_ff;
   assign rsp_chan.poll_interval    = rsp_iv_ff;

endmodule

`default_nettype wire

@@ hw/rtl/hkds_checker.sv @@
// Port-level checks for the keyboard descriptor scanner, bound to the top
// level. Depends on hkds_pkg and hid_keyboard_descriptor_scanner.
`timescale 1ns / 1ps
`default_nettype none

module hkds_checker import hkds_pkg::*; (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       req_last,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [1:0] rsp_status,
   input wire [7:0] rsp_if,
   input wire [7:0] rsp_ep,
   input wire [7:0] rsp_iv
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_if) && $stable(rsp_ep) && $stable(rsp_iv))
      else $error("stalled result changed");

   // a marked request yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid)
      else $error("marked request gave no result");

   // a result appears only after a marked request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last))
      else $error("result without marked request");

   // value fields are zero unless found; a found endpoint is IN
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_FOUND) ? rsp_ep[7] :
         (rsp_if == 8'd0 && rsp_ep == 8'd0 && rsp_iv == 8'd0))
      else $error("result fields inconsistent with status");

endmodule

bind hid_keyboard_descriptor_scanner hkds_checker u_hkds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_last   (req_chan.last_byte),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.scan_status),
   .rsp_if     (rsp_chan.interface_number),
   .rsp_ep     (rsp_chan.endpoint_address),
   .rsp_iv     (rsp_chan.poll_interval)
);

`default_nettype wire

@@ bench/hid_keyboard_descriptor_scanner_tb.sv @@
// Self-checking bench for the keyboard descriptor scanner: byte streams in,
// scan results checked against a cycle-free model kept in a scoreboard class.
// Depends on hkds_pkg, the channel interfaces and the scanner top level.
`timescale 1ns / 1ps

module hid_keyboard_descriptor_scanner_tb;
   import hkds_pkg::*;

   // One scan result as the block reports it.
   typedef struct packed {
      status_type status;
      logic [7:0] iface_num;
      logic [7:0] ep_addr;
      logic [7:0] interval;
   } scan_outcome_type;

   // Scoreboard: mirrors the scan registers, turns every accepted byte request
   // that carries last_byte into an expected outcome and checks outcomes as they leave.
   class keyboard_scan_scoreboard;
      logic [7:0]       want_class, want_subclass, want_protocol;
      logic [7:0]       pos, len, dtype;
      phase_type        stage;
      logic [7:0]       grab [3];
      logic [7:0]       hit_iface, hit_ep, hit_interval;
      scan_outcome_type pending_outcomes [$];
      int unsigned      mismatches, found_count, bad_count, none_count;

      function new();
         want_class    = RESET_MATCH_CLASS;
         want_subclass = RESET_MATCH_SUBCLASS;
         want_protocol = RESET_MATCH_PROTOCOL;
         mismatches    = 0;
         found_count   = 0;
         bad_count     = 0;
         none_count    = 0;
         restart();
      endfunction

      function void restart();
         pos          = 0;
         len          = 0;
         dtype        = 0;
         stage        = PH_HEADER;
         foreach (grab[i]) grab[i] = 0;
         hit_iface    = 0;
         hit_ep       = 0;
         hit_interval = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [7:0] v);
         case (idx)
            CSR_MATCH_CLASS:    want_class    = v;
            CSR_MATCH_SUBCLASS: want_subclass = v;
            CSR_MATCH_PROTOCOL: want_protocol = v;
            default: ;
         endcase
      endfunction

      // One byte of an ordinary descriptor while searching.
      function void step_descriptor(logic [7:0] b);
         logic [7:0] at;
         at = pos;
         if (at == 0) begin
            len   = b;
            dtype = 0;
            if (b == 0) begin
               stage = PH_STOPPED;
               return;
            end
         end else if (at == 1) begin
            dtype = b;
            if (b == TYPE_INTERFACE) stage = PH_SEARCH;
         end else if (dtype == TYPE_INTERFACE && stage == PH_SEARCH) begin
            // interface: number at 2, class/subclass/protocol at 5..7
            case (at)
               2: grab[0] = b;
               5: grab[1] = b;
               6: grab[2] = b;
               7: if (grab[1] == want_class && grab[2] == want_subclass &&
                      b == want_protocol) begin
                     hit_iface = grab[0];
                     stage     = PH_IN_IFACE;
                  end
               default: ;
            endcase
         end else if (dtype == TYPE_ENDPOINT && stage == PH_IN_IFACE) begin
            // endpoint: address at 2, attributes at 3, interval at 6
            case (at)
               2: grab[0] = b;
               3: grab[1] = b;
               6: if ((grab[1] & XFER_MASK) == XFER_INTERRUPT &&
                      (grab[0] & DIR_IN) != 0) begin
                     hit_ep       = grab[0];
                     hit_interval = b;
                     stage        = PH_FOUND;
                     return;
                  end
               default: ;
            endcase
         end
         if (int'(at) + 1 >= int'(len)) pos = 0;
         else pos = at + 8'd1;
      endfunction

      // Length and type byte of the configuration header.
      function void step_header(logic [7:0] b);
         if (pos == 0) begin
            len = b;
            pos = 1;
            return;
         end
         if (b != TYPE_CONFIGURATION) begin
            stage = PH_BAD;
            return;
         end
         stage = PH_SEARCH;
         dtype = b;
         if (len == 0) begin
            stage = PH_STOPPED;
         end else if (len == 1) begin
            // the type byte doubles as the next length byte
            pos = 0;
            step_descriptor(b);
         end else if (len == 2) begin
            pos = 0;
         end else begin
            pos = 2;
         end
      endfunction

      function void note_request(logic [7:0] b, logic last);
         scan_outcome_type o;
         if (stage == PH_HEADER) step_header(b);
         else if (stage == PH_SEARCH || stage == PH_IN_IFACE) step_descriptor(b);
         if (!last) return;
         o.iface_num = 0;
         o.ep_addr   = 0;
         o.interval  = 0;
         if (stage == PH_FOUND) begin
            o.status    = ST_FOUND;
            o.iface_num = hit_iface;
            o.ep_addr   = hit_ep;
            o.interval  = hit_interval;
            found_count++;
         end else if (stage == PH_HEADER || stage == PH_BAD) begin
            o.status = ST_BAD_HEADER;
            bad_count++;
         end else begin
            o.status = ST_NOT_FOUND;
            none_count++;
         end
         pending_outcomes.push_back(o);
         restart();
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("[%0t] scan check failed: %0s", $time, what);
      endtask

      task check_result(logic [1:0] st, logic [7:0] num, logic [7:0] ep, logic [7:0] iv);
         scan_outcome_type o;
         if (pending_outcomes.size() == 0) begin
            report($sformatf("result with none pending, status %0d", st));
            return;
         end
         o = pending_outcomes.pop_front();
         if (st !== o.status)
            report($sformatf("scan_status %0d, want %0d", st, o.status));
         if (num !== o.iface_num)
            report($sformatf("interface_number %0h, want %0h", num, o.iface_num));
         if (ep !== o.ep_addr)
            report($sformatf("endpoint_address %0h, want %0h", ep, o.ep_addr));
         if (iv !== o.interval)
            report($sformatf("poll_interval %0h, want %0h", iv, o.interval));
      endtask
   endclass

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [7:0] DESC_TYPE_HID = 8'h21;
   localparam int unsigned RESET_CYCLES = 8;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned PHASES       = 6;
   localparam int unsigned PHASE_BYTES  = 165;

   logic clock;
   logic reset;

   hkds_req_if req_bus ();
   hkds_rsp_if rsp_bus ();
   hkds_csr_if csr_bus ();

   hid_keyboard_descriptor_scanner i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   keyboard_scan_scoreboard sb;

   // Stream under construction and the match values currently programmed,
   // so the generator can aim interfaces at them.
   logic [7:0]  stream_bytes [$];
   logic [7:0]  desc_body [16];
   logic [7:0]  cfg_class, cfg_subclass, cfg_protocol;
   int unsigned streams_sent, bytes_sent, settings_used;

   // Free-running 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake hangs.
   initial begin
      #5_000_000;
      $display("hid_keyboard_descriptor_scanner: mismatch");
      $finish;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void fill_body();
      foreach (desc_body[i]) desc_body[i] = 8'($urandom_range(0, 255));
   endfunction

   // Append one descriptor: length byte, type byte, then body bytes up to len.
   function automatic void push_desc(int unsigned len, logic [7:0] dtype);
      stream_bytes.push_back(8'(len));
      for (int i = 1; i < len; i++)
         stream_bytes.push_back((i == 1) ? dtype : desc_body[i]);
   endfunction

   // Interface aimed at the match registers; when not matching, spoil one field.
   function automatic void add_interface(int unsigned len, bit matching);
      int unsigned k;
      fill_body();
      desc_body[5] = cfg_class;
      desc_body[6] = cfg_subclass;
      desc_body[7] = cfg_protocol;
      if (!matching) begin
         k = $urandom_range(5, 7);
         desc_body[k] ^= 8'($urandom_range(1, 255));
      end
      push_desc(len, TYPE_INTERFACE);
   endfunction

   // Endpoint; a good one is forced to interrupt IN, otherwise left random.
   function automatic void add_endpoint(int unsigned len, bit good);
      fill_body();
      if (good) begin
         desc_body[2] |= DIR_IN;
         desc_body[3] |= XFER_INTERRUPT;
      end
      push_desc(len, TYPE_ENDPOINT);
   endfunction

   function automatic void add_other(int unsigned len, logic [7:0] dtype);
      fill_body();
      push_desc(len, dtype);
   endfunction

   function automatic void add_random_desc();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 30)
         add_interface(($urandom_range(0, 4) == 0) ? $urandom_range(3, 10) : 9,
                       $urandom_range(0, 2) != 0);
      else if (k < 60)
         add_endpoint(($urandom_range(0, 4) == 0) ? $urandom_range(3, 9) : 7,
                      $urandom_range(0, 2) != 0);
      else if (k < 90)
         add_other($urandom_range(1, 12),
                   $urandom_range(0, 1) ? DESC_TYPE_HID : 8'($urandom_range(0, 255)));
      else
         stream_bytes.push_back(8'h00);   // zero length: halts the scan
   endfunction

   // Build one stream: mostly a proper header and descriptor chain with random
   // content, some of it keyboard-shaped; the rest cut off, padded or pure noise.
   function automatic void make_stream();
      int unsigned r;
      int unsigned hdr_len;
      int unsigned cut;
      r = $urandom_range(0, 99);
      stream_bytes.delete();
      if (r >= 90) begin
         repeat ($urandom_range(1, 24)) stream_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      fill_body();
      hdr_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 9;
      stream_bytes.push_back(8'(hdr_len));
      stream_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                          : TYPE_CONFIGURATION);
      for (int i = 2; i < hdr_len; i++) stream_bytes.push_back(desc_body[i]);
      if (r < 50) begin
         add_interface(9, $urandom_range(0, 4) != 0);
         add_other(9, DESC_TYPE_HID);
         add_endpoint(7, $urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) add_endpoint(7, $urandom_range(0, 1) != 0);
      end
      repeat ($urandom_range((r < 50) ? 0 : 1, 3)) add_random_desc();
      case ($urandom_range(0, 9))
         0: begin
            cut = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
         end
         1: repeat ($urandom_range(1, 6)) stream_bytes.push_back(8'($urandom_range(0, 255)));
         default: ;
      endcase
   endfunction

   // Present one byte request and hold it until the scanner takes it.
   // Valid is left high; the caller drops it when a gap follows.
   task automatic send_byte(logic [7:0] b, logic last);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Send the built stream, mark its final byte, and idle between requests
   // unless this stream runs as a burst.
   task automatic send_stream();
      bit          burst;
      int unsigned gap;
      burst = ($urandom_range(0, 4) == 0);
      foreach (stream_bytes[i]) begin
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
         gap = burst ? 0 : idle_cycles();
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      streams_sent++;
      bytes_sent += stream_bytes.size();
   endtask

   // Drop valid, wait for every pending result, then let the pipe settle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Single register write; valid stays high for a following write.
   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [7:0] v);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data   <= v;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // Program all three match values, with a stray write to the unused index
   // in between that must leave them alone.
   task automatic write_setting(input logic [7:0] c, input logic [7:0] s,
                                input logic [7:0] p);
      csr_write(CSR_MATCH_CLASS, c);
      csr_write(CSR_MATCH_SUBCLASS, s);
      csr_write(CSR_UNUSED_INDEX, 8'($urandom_range(0, 255)));
      csr_write(CSR_MATCH_PROTOCOL, p);
      csr_bus.valid <= 1'b0;
      cfg_class    = c;
      cfg_subclass = s;
      cfg_protocol = p;
      settings_used++;
   endtask

   // Result side: accept for a while, then stall; long open stretches now and
   // then so back-to-back results also get through.
   initial begin
      int unsigned open_len;
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
         rsp_bus.ready <= 1'b1;
         repeat (open_len) @(posedge clock);
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Watch all three channels at the edge: feed accepted requests and writes
   // to the model, check every accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.set_reg(csr_bus.reg_index, csr_bus.wr_data);
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.data_byte, req_bus.last_byte);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.scan_status, rsp_bus.interface_number,
                            rsp_bus.endpoint_address, rsp_bus.poll_interval);
      end
   end

   initial begin
      int unsigned phase_bytes;
      sb            = new();
      streams_sent  = 0;
      bytes_sent    = 0;
      settings_used = 0;
      cfg_class     = RESET_MATCH_CLASS;
      cfg_subclass  = RESET_MATCH_SUBCLASS;
      cfg_protocol  = RESET_MATCH_PROTOCOL;

      // Hold every input at a known value from time zero.
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.reg_index <= CSR_MATCH_CLASS;
      csr_bus.wr_data   <= 8'h00;
      reset             <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed streams at the reset match values (boot keyboard).
      // Stream ends before the header type byte: bad header.
      stream_bytes = '{8'hFF};
      send_stream();
      // Header of length zero with a proper type: not found.
      stream_bytes = '{8'h00, TYPE_CONFIGURATION};
      send_stream();
      // Wrong header type: bad header.
      stream_bytes = '{8'h05, 8'h03};
      send_stream();
      // Header of length one: its type byte opens a two-byte descriptor,
      // then a zero-length descriptor halts the scan.
      stream_bytes = '{8'h01, TYPE_CONFIGURATION, TYPE_INTERFACE, 8'h00};
      send_stream();
      // Shortest keyboard: two-byte header, eight-byte interface, endpoint
      // with all-ones address and attributes, then a byte after the decision.
      stream_bytes = '{TYPE_CONFIGURATION, TYPE_CONFIGURATION,
                       8'h08, TYPE_INTERFACE, 8'hFF, 8'h00, 8'h00,
                       RESET_MATCH_CLASS, RESET_MATCH_SUBCLASS, RESET_MATCH_PROTOCOL,
                       8'h07, TYPE_ENDPOINT, 8'hFF, 8'hFF, 8'h08, 8'h00, 8'h00,
                       8'hFF};
      send_stream();
      drain();

      // Random phases, each under its own match setting, extremes first.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: write_setting(8'h00, 8'h00, 8'h00);
            1: write_setting(8'hFF, 8'hFF, 8'hFF);
            2: write_setting(RESET_MATCH_CLASS, RESET_MATCH_SUBCLASS, RESET_MATCH_PROTOCOL);
            default: write_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)));
         endcase
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            make_stream();
            phase_bytes += stream_bytes.size();
            send_stream();
         end
         drain();
      end

      $display("covered %0d streams, %0d byte requests, %0d match settings",
               streams_sent, bytes_sent, settings_used);
      $display("outcomes: %0d keyboards found, %0d bad headers, %0d without keyboard",
               sb.found_count, sb.bad_count, sb.none_count);
      if (sb.mismatches == 0) begin
         $display("hid_keyboard_descriptor_scanner: match");
      end else begin
         $display("hid_keyboard_descriptor_scanner: mismatch");
      end
      $finish;
   end

endmodule
